/* hdl/iffmt_pkg.sv */
// Shared types and constants for the integer field formatter.
package iffmt_pkg;

	// Defaults for the top-level parameters.
	localparam int VALUE_BITS_DEF      = 64;
	localparam int MAX_FIELD_WIDTH_DEF = 64;

	// Width of one slice of the value handled by the divide step.
	localparam int CHUNK_W = 16;

	// Character counts and field positions never exceed 64, so 7 bits hold them.
	localparam int CNT_W = 7;

	// Digit buffer: at most 30 extracted digits plus the octal alternate zero.
	localparam int DIG_DEPTH   = 32;
	localparam int DIG_IDX_W   = 5;
	localparam int DIG_CNT_W   = 6;
	localparam int DIGIT_CAP   = 30;

	// Hard limit on the characters of one field.
	localparam int MAX_CHARS = 64;

	// Conversion modes.
	localparam logic [2:0] MODE_SDEC   = 3'd0;
	localparam logic [2:0] MODE_UDEC   = 3'd1;
	localparam logic [2:0] MODE_OCT    = 3'd2;
	localparam logic [2:0] MODE_HEX    = 3'd3;
	localparam logic [2:0] MODE_HEX_UP = 3'd4;
	localparam logic [2:0] MODE_PTR    = 3'd5;

	// ASCII characters used in a field.
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_A_UP  = 8'h41;
	localparam logic [7:0] CH_A_LO  = 8'h61;

	typedef enum logic [1:0] {
		BASE_DEC,
		BASE_OCT,
		BASE_HEX
	} base_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_LAYOUT,
		ST_PLACE,
		ST_EMIT
	} state_t;

	// Segment boundaries of a field, each the position one past the segment.
	typedef struct packed {
		logic [CNT_W-1:0] lead_end;
		logic [CNT_W-1:0] sign_end;
		logic [CNT_W-1:0] prefix_end;
		logic [CNT_W-1:0] zero_end;
		logic [CNT_W-1:0] digit_end;
		logic [7:0]       sign_ch;
		logic             upper;
	} layout_t;

endpackage

/* hdl/iffmt_div_step.sv */
// One long-division step: divides a remainder and a 16-bit slice by the base.
module iffmt_div_step import iffmt_pkg::*; (
	input  base_t              base,
	input  logic [3:0]         rem_in,
	input  logic [CHUNK_W-1:0] chunk,
	output logic [CHUNK_W-1:0] quot,
	output logic [3:0]         rem_out
);

	// ceil(2^23 / 10); exact for every dividend below 2^22.
	localparam logic [19:0] DEC_RECIP = 20'd838861;

	logic [19:0] x_dec;
	logic [39:0] prod;
	logic [15:0] q_dec;
	logic [19:0] q_times_ten;
	logic [19:0] r_dec;

	assign x_dec       = {rem_in, chunk};
	assign prod        = 40'(x_dec) * 40'(DEC_RECIP);
	assign q_dec       = prod[38:23];
	assign q_times_ten = 20'({q_dec, 3'b000}) + 20'({q_dec, 1'b0});
	assign r_dec       = x_dec - q_times_ten;

	always_comb begin
		case (base)
			BASE_HEX: begin
				quot    = {rem_in, chunk[15:4]};
				rem_out = chunk[3:0];
			end
			BASE_OCT: begin
				quot    = {rem_in[2:0], chunk[15:3]};
				rem_out = {1'b0, chunk[2:0]};
			end
			default: begin
				quot    = q_dec;
				rem_out = r_dec[3:0];
			end
		endcase
	end

endmodule

/* hdl/iffmt_char_sel.sv */
// Picks the character at one position of a laid-out field.
module iffmt_char_sel import iffmt_pkg::*; (
	input  layout_t              lay,
	input  logic [CNT_W-1:0]     pos,
	input  logic [3:0]           digit,
	output logic [DIG_IDX_W-1:0] dig_idx,
	output logic [7:0]           ascii_char
);

	logic [CNT_W-1:0] rev;
	logic [7:0]       digit_ch;

	// Digits are stored least significant first, so read them backward.
	assign rev     = lay.digit_end - CNT_W'(1) - pos;
	assign dig_idx = rev[DIG_IDX_W-1:0];

	always_comb begin
		if (digit < 4'd10) begin
			digit_ch = CH_ZERO + 8'(digit);
		end else if (lay.upper) begin
			digit_ch = CH_A_UP + 8'(digit - 4'd10);
		end else begin
			digit_ch = CH_A_LO + 8'(digit - 4'd10);
		end
	end

	always_comb begin
		if (pos < lay.lead_end) begin
			ascii_char = CH_SPACE;
		end else if (pos < lay.sign_end) begin
			ascii_char = lay.sign_ch;
		end else if (pos < lay.prefix_end) begin
			if (pos == lay.sign_end) begin
				ascii_char = CH_ZERO;
			end else begin
				ascii_char = lay.upper ? CH_X_UP : CH_X_LO;
			end
		end else if (pos < lay.zero_end) begin
			ascii_char = CH_ZERO;
		end else if (pos < lay.digit_end) begin
			ascii_char = digit_ch;
		end else begin
			ascii_char = CH_SPACE;
		end
	end

endmodule

/* hdl/integer_field_formatter.sv */
// Top level of the integer field formatter: sequencer, digit buffer and output register.
//
// The formatter turns one integer item into the ASCII characters of a printf-style
// field. An item (magnitude, negative mark, mode, flags, width, precision) is taken
// on the item channel when item_valid is high and item_stall is low. The characters
// leave on the char channel, one per accepted transfer, most significant first, with
// last set on the final character. A field may have no characters at all; then the
// item produces nothing on the char channel.
//
// The item channel stalls from acceptance until the final character has been loaded
// into the output register. Digits come from one shared divide step that works on
// 16-bit slices, one slice per step, so each digit takes a full pass over the slices
// of the value. The division is followed by the layout and placement states, and
// then the characters leave one per cycle while the receiver does not stall.
//
// A stall on the char channel holds the current character and freezes emission; the
// output register lets the next item be accepted while the final character waits.
// Reset empties the output register and returns the sequencer to idle.
module integer_field_formatter import iffmt_pkg::*; #(
	parameter int VALUE_BITS      = VALUE_BITS_DEF,
	parameter int MAX_FIELD_WIDTH = MAX_FIELD_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [63:0] magnitude,
	input  logic        negative,
	input  logic [2:0]  mode,
	input  logic        left_justify,
	input  logic        force_plus,
	input  logic        space_sign,
	input  logic        alternate_form,
	input  logic        zero_fill,
	input  logic [6:0]  field_width,
	input  logic        has_precision,
	input  logic [5:0]  precision,
	output logic        char_valid,
	input  logic        char_stall,
	output logic [7:0]  ascii_char,
	output logic        last
);

	localparam int CHUNKS = (VALUE_BITS + CHUNK_W - 1) / CHUNK_W;
	localparam int T_W    = CHUNKS * CHUNK_W;
	localparam int CIDX_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam logic [CIDX_W-1:0] CIDX_TOP  = CIDX_W'(CHUNKS - 1);
	localparam logic [CNT_W-1:0]  WIDTH_MAX = CNT_W'(MAX_FIELD_WIDTH);
	localparam logic [5:0]        PREC_MAX  = 6'(MAX_FIELD_WIDTH - 3);
	localparam logic [CNT_W-1:0]  CHARS_MAX = CNT_W'(MAX_CHARS);

	state_t state_q, state_d;

	// Control strobes from the sequencer.
	logic load_item, div_step, do_layout, do_place, emit_fire;

	// Working value and division state.
	logic [CHUNK_W-1:0]   t_q [CHUNKS];
	logic [CIDX_W-1:0]    cidx_q;
	logic [3:0]           rem_q;
	logic                 nz_q;
	logic [DIG_CNT_W-1:0] ndig_q;
	logic [3:0]           digs_q [DIG_DEPTH];

	// Item attributes captured at acceptance.
	base_t            base_q;
	logic             upper_q, hash_q, vnz_q, left_q, zero_q, prec_given_q;
	logic [5:0]       prec_q;
	logic [CNT_W-1:0] width_q;
	logic             has_sign_q, has_px_q;
	logic [7:0]       sign_ch_q;

	// Layout results.
	logic [CNT_W-1:0] ndig_fin_q, zpad_q, spaces_q, n_q, pos_q;
	layout_t          lay_q;

	// Output register.
	logic       char_valid_q, last_q;
	logic [7:0] ascii_char_q;

	// Decode of the incoming item.
	base_t             base_in;
	logic              upper_in, show_sign_in, neg_in, hash_in, vnz_in;
	logic [VALUE_BITS-1:0] vmask;
	logic [T_W-1:0]    tval;

	assign vmask = magnitude[VALUE_BITS-1:0];
	assign tval  = T_W'(vmask);
	assign vnz_in = |vmask;

	always_comb begin
		base_in      = BASE_DEC;
		upper_in     = 1'b0;
		show_sign_in = 1'b0;
		case (mode)
			MODE_SDEC: begin
				show_sign_in = 1'b1;
			end
			MODE_OCT: begin
				base_in = BASE_OCT;
			end
			MODE_HEX: begin
				base_in = BASE_HEX;
			end
			MODE_HEX_UP: begin
				base_in  = BASE_HEX;
				upper_in = 1'b1;
			end
			MODE_PTR: begin
				base_in      = BASE_HEX;
				show_sign_in = 1'b1;
			end
			default: begin
				base_in = BASE_DEC;
			end
		endcase
	end

	// The negative mark only counts in signed decimal; pointer mode forces the hash flag.
	assign neg_in  = negative && (mode == MODE_SDEC);
	assign hash_in = alternate_form || (mode == MODE_PTR);

	// Shared divide step.
	logic [CHUNK_W-1:0] quot;
	logic [3:0]         rem_next;
	logic               pass_end, more_digits;

	iffmt_div_step u_div (
		.base    (base_q),
		.rem_in  (rem_q),
		.chunk   (t_q[cidx_q]),
		.quot    (quot),
		.rem_out (rem_next)
	);

	assign pass_end    = (cidx_q == '0);
	assign more_digits = (nz_q || (quot != '0)) &&
		((ndig_q + DIG_CNT_W'(1)) < DIG_CNT_W'(DIGIT_CAP));

	// Layout: digit count, zero padding and space count.
	logic                 oct_zero, prec_kill, zfill;
	logic [DIG_CNT_W-1:0] ndig_raw;
	logic [CNT_W-1:0]     ndig_fin_d, npre, prec_c, zpad0, total0, total1;
	logic [CNT_W-1:0]     zpad_d, spaces_d;

	// Octal alternate form folds a zero into the digits of a nonzero value.
	assign oct_zero  = (base_q == BASE_OCT) && hash_q && vnz_q;
	assign ndig_raw  = ndig_q + DIG_CNT_W'(oct_zero);
	// A zero value with precision zero has no digits, except in octal alternate form.
	assign prec_kill = prec_given_q && (prec_q == '0) && !vnz_q &&
		!((base_q == BASE_OCT) && hash_q);
	assign ndig_fin_d = prec_kill ? '0 : CNT_W'(ndig_raw);
	assign npre   = CNT_W'(has_sign_q) + (has_px_q ? CNT_W'(2) : '0);
	assign prec_c = CNT_W'(prec_q);
	assign zpad0  = (prec_given_q && (ndig_fin_d < prec_c)) ? (prec_c - ndig_fin_d) : '0;
	assign total0 = npre + zpad0 + ndig_fin_d;
	// Zero fill only applies with no precision and right justification.
	assign zfill  = zero_q && !prec_given_q && !left_q && (total0 < width_q);
	assign zpad_d = zfill ? (zpad0 + (width_q - total0)) : zpad0;
	assign total1 = zfill ? width_q : total0;
	assign spaces_d = (width_q > total1) ? (width_q - total1) : '0;

	// Placement: segment boundaries and the character count.
	layout_t          lay_d;
	logic [CNT_W-1:0] lead, total_d, n_d;

	assign lead = left_q ? '0 : spaces_q;

	always_comb begin
		lay_d.lead_end   = lead;
		lay_d.sign_end   = lead + CNT_W'(has_sign_q);
		lay_d.prefix_end = lay_d.sign_end + (has_px_q ? CNT_W'(2) : '0);
		lay_d.zero_end   = lay_d.prefix_end + zpad_q;
		lay_d.digit_end  = lay_d.zero_end + ndig_fin_q;
		lay_d.sign_ch    = sign_ch_q;
		lay_d.upper      = upper_q;
	end

	assign total_d = lay_d.digit_end + (left_q ? spaces_q : '0);
	assign n_d     = (total_d > CHARS_MAX) ? CHARS_MAX : total_d;

	// Character selection for the current position.
	logic [DIG_IDX_W-1:0] dig_idx;
	logic [7:0]           cur_char;
	logic                 last_now;

	iffmt_char_sel u_sel (
		.lay        (lay_q),
		.pos        (pos_q),
		.digit      (digs_q[dig_idx]),
		.dig_idx    (dig_idx),
		.ascii_char (cur_char)
	);

	assign last_now = (pos_q == (n_q - CNT_W'(1)));

	// Sequencer: next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (pass_end && !more_digits) begin
					state_d = ST_LAYOUT;
				end
			end
			ST_LAYOUT: begin
				state_d = ST_PLACE;
			end
			ST_PLACE: begin
				state_d = (n_d == '0) ? ST_IDLE : ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_fire && last_now) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer: control strobes.
	always_comb begin
		load_item = 1'b0;
		div_step  = 1'b0;
		do_layout = 1'b0;
		do_place  = 1'b0;
		emit_fire = 1'b0;
		case (state_q)
			ST_IDLE: begin
				load_item = item_valid;
			end
			ST_DIVIDE: begin
				div_step = 1'b1;
			end
			ST_LAYOUT: begin
				do_layout = 1'b1;
			end
			ST_PLACE: begin
				do_place = 1'b1;
			end
			ST_EMIT: begin
				emit_fire = !char_valid_q || !char_stall;
			end
			default: begin
				load_item = 1'b0;
			end
		endcase
	end

	assign item_stall = (state_q != ST_IDLE);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			char_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_fire) begin
				char_valid_q <= 1'b1;
			end else if (!char_stall) begin
				char_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (load_item) begin
			for (int c = 0; c < CHUNKS; c++) begin
				t_q[c] <= tval[c*CHUNK_W +: CHUNK_W];
			end
			cidx_q       <= CIDX_TOP;
			rem_q        <= '0;
			nz_q         <= 1'b0;
			ndig_q       <= '0;
			base_q       <= base_in;
			upper_q      <= upper_in;
			hash_q       <= hash_in;
			vnz_q        <= vnz_in;
			left_q       <= left_justify;
			zero_q       <= zero_fill;
			prec_given_q <= has_precision;
			prec_q       <= (precision > PREC_MAX) ? PREC_MAX : precision;
			width_q      <= (field_width > WIDTH_MAX) ? WIDTH_MAX : field_width;
			// Sign priority: minus, then plus, then space.
			has_sign_q <= show_sign_in && (neg_in || force_plus || space_sign);
			sign_ch_q  <= neg_in ? CH_MINUS : (force_plus ? CH_PLUS : CH_SPACE);
			has_px_q   <= (base_in == BASE_HEX) && hash_in && vnz_in;
		end

		if (div_step) begin
			t_q[cidx_q] <= quot;
			if (pass_end) begin
				// The remainder of a full pass is the next digit.
				digs_q[ndig_q[DIG_IDX_W-1:0]] <= rem_next;
				ndig_q <= ndig_q + DIG_CNT_W'(1);
				cidx_q <= CIDX_TOP;
				rem_q  <= '0;
				nz_q   <= 1'b0;
			end else begin
				cidx_q <= cidx_q - CIDX_W'(1);
				rem_q  <= rem_next;
				nz_q   <= nz_q || (quot != '0);
			end
		end

		if (do_layout) begin
			if (oct_zero) begin
				digs_q[ndig_q[DIG_IDX_W-1:0]] <= 4'd0;
			end
			ndig_fin_q <= ndig_fin_d;
			zpad_q     <= zpad_d;
			spaces_q   <= spaces_d;
		end

		if (do_place) begin
			lay_q <= lay_d;
			n_q   <= n_d;
			pos_q <= '0;
		end

		if (emit_fire) begin
			ascii_char_q <= cur_char;
			last_q       <= last_now;
			pos_q        <= pos_q + CNT_W'(1);
		end
	end

	assign char_valid = char_valid_q;
	assign ascii_char = ascii_char_q;
	assign last       = last_q;

	// Emission never runs past the character count of the field.
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (pos_q < n_q))
		else $error("emission position beyond field length");

	// Loading the final character ends the field.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && last_now) |=> (state_q == ST_IDLE) && char_valid && last)
		else $error("final character did not end the field");

	// An accepted item starts a fresh division pass.
	a_item_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> (state_q == ST_DIVIDE) && (rem_q == '0) &&
			(ndig_q == '0))
		else $error("item did not start a clean division");

	// A decimal remainder stays a decimal digit.
	a_dec_rem: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DIVIDE) && (base_q == BASE_DEC)) |-> (rem_q < 4'd10))
		else $error("decimal remainder out of range");

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the integer field formatter.
//
// Every item handed to the formatter is also run through a behavioral formatter
// kept here, which lays out the expected field (leading spaces, sign, hex prefix,
// zero padding, digits, trailing spaces) and queues its characters. A monitor
// compares every character that leaves the block, and its last mark, against the
// oldest queued character. Items come first from a short directed list that walks
// the corner cases (empty fields, negative zero, prefix rules, zero fill being
// overridden, saturated width and precision, unused mode codes) and then from a
// random mix that leans on short fields so the run stays quick.
module tb;
	import iffmt_pkg::*;

	// The two mode codes the block does not name; they format as unsigned decimal.
	localparam logic [2:0] MODE_UNUSED6 = 3'd6;
	localparam logic [2:0] MODE_UNUSED7 = 3'd7;

	// Flag bits as packed by make_field: {left, plus, space, alternate, zero}.
	localparam logic [4:0] FL_NONE  = 5'b00000;
	localparam logic [4:0] FL_LEFT  = 5'b10000;
	localparam logic [4:0] FL_PLUS  = 5'b01000;
	localparam logic [4:0] FL_SPACE = 5'b00100;
	localparam logic [4:0] FL_ALT   = 5'b00010;
	localparam logic [4:0] FL_ZERO  = 5'b00001;

	localparam int RANDOM_FIELDS  = 155;
	localparam int IDLE_PERCENT   = 16;
	// A 64-bit octal value needs 22 digits plus layout; the
	// quiet time at the end covers that twice over.
	localparam int SETTLE_CYCLES  = 200;
	// No transfer on either channel for this long means the block is stuck.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 30;

	typedef struct packed {
		logic [63:0] mag;
		logic        neg;
		logic [2:0]  mode;
		logic        left;
		logic        plus;
		logic        space;
		logic        alt;
		logic        zfill;
		logic [6:0]  width;
		logic        prec_given;
		logic [5:0]  prec;
		logic        hold;  // wait for every queued character before sending
	} field_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [63:0] magnitude = '0;
	logic        negative = 1'b0;
	logic [2:0]  mode = MODE_SDEC;
	logic        left_justify = 1'b0;
	logic        force_plus = 1'b0;
	logic        space_sign = 1'b0;
	logic        alternate_form = 1'b0;
	logic        zero_fill = 1'b0;
	logic [6:0]  field_width = '0;
	logic        has_precision = 1'b0;
	logic [5:0]  precision = '0;
	logic        char_valid;
	logic        char_stall = 1'b0;
	logic [7:0]  ascii_char;
	logic        last;

	// Items still to be sent, the item on the bus, and the characters that the
	// accepted items must still produce, each as {last, character}.
	field_item_t fields_to_send[$];
	field_item_t on_bus;
	logic [8:0]  expected_chars[$];
	logic [8:0]  next_char;

	int errors = 0;
	int fields_sent = 0;
	int empty_fields = 0;
	int chars_checked = 0;
	int idle_cycles = 0;
	logic steady;

	integer_field_formatter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.magnitude     (magnitude),
		.negative      (negative),
		.mode          (mode),
		.left_justify  (left_justify),
		.force_plus    (force_plus),
		.space_sign    (space_sign),
		.alternate_form(alternate_form),
		.zero_fill     (zero_fill),
		.field_width   (field_width),
		.has_precision (has_precision),
		.precision     (precision),
		.char_valid    (char_valid),
		.char_stall    (char_stall),
		.ascii_char    (ascii_char),
		.last          (last)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Reset is released on a falling edge so that its release never coincides
	// with a sampling edge.
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Neither side idles while this many items have gone through, which gives
	// one long back-to-back stretch in the middle of the run.
	assign steady = (fields_sent >= 70) && (fields_sent < 120);

	function automatic field_item_t make_field(input logic [63:0] m, input logic [2:0] md,
			input logic [4:0] fl, input int w, input int hp,
			input int p, input int ng);
		field_item_t f;
		f.mag = m;
		f.neg = 1'(ng);
		f.mode = md;
		{f.left, f.plus, f.space, f.alt, f.zfill} = fl;
		f.width = 7'(w);
		f.prec_given = 1'(hp);
		f.prec = 6'(p);
		f.hold = 1'b0;
		return f;
	endfunction

	// Random item. Values come in several shapes so that short and long digit
	// strings, zero and the all-ones value all turn up; widths stay mostly small
	// so that the run stays quick.
	function automatic field_item_t random_field();
		field_item_t f;
		f.mag = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: f.mag = '0;
			1: f.mag = 64'($urandom_range(0, 20));
			2: f.mag = 64'($urandom);
			3: ;
			4: f.mag = $urandom_range(0, 1) ? {64{1'b1}} : (64'd1 << $urandom_range(0, 63));
			default: f.mag = f.mag >> $urandom_range(0, 63);
		endcase
		f.neg = 1'($urandom_range(0, 1));
		f.mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
			: 3'($urandom_range(0, 5));
		{f.left, f.plus, f.space, f.alt, f.zfill} = 5'($urandom);
		case ($urandom_range(0, 9))
			0: f.width = 7'($urandom_range(65, 127));
			1, 2: f.width = 7'($urandom_range(25, 64));
			default: f.width = 7'($urandom_range(0, 24));
		endcase
		f.prec_given = ($urandom_range(0, 9) < 4);
		f.prec = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 8))
			: 6'($urandom_range(0, 63));
		f.hold = 1'b0;
		return f;
	endfunction

	// Lays out the field for one accepted item and queues its characters.
	task automatic format_field(input field_item_t f);
		logic [63:0] rest;
		logic [7:0]  digits [0:31];
		logic [7:0]  prefix [0:2];
		logic [7:0]  line [0:MAX_CHARS-1];
		logic [7:0]  d;
		logic        upper, signed_kind, alt, neg;
		int radix, ndig, npre, zpad, total, spaces, w, p, n, i;
		upper = 1'b0;
		signed_kind = 1'b0;
		alt = f.alt;
		neg = 1'b0;
		ndig = 0;
		npre = 0;
		n = 0;
		w = (f.width > MAX_FIELD_WIDTH_DEF) ? MAX_FIELD_WIDTH_DEF : int'(f.width);
		p = (f.prec > MAX_FIELD_WIDTH_DEF - 3) ? MAX_FIELD_WIDTH_DEF - 3 : int'(f.prec);

		// Only signed decimal looks at the negative mark; pointer mode is hex with
		// a forced prefix that still takes a plus or space sign.
		case (f.mode)
			MODE_SDEC: begin
				radix = 10;
				signed_kind = 1'b1;
				neg = f.neg;
			end
			MODE_OCT:    radix = 8;
			MODE_HEX:    radix = 16;
			MODE_HEX_UP: begin
				radix = 16;
				upper = 1'b1;
			end
			MODE_PTR: begin
				radix = 16;
				signed_kind = 1'b1;
				alt = 1'b1;
			end
			default:     radix = 10;
		endcase

		// Digits are collected least significant first.
		rest = f.mag;
		do begin
			d = 8'(rest % 64'(radix));
			digits[ndig] = (d < 10) ? CH_ZERO + d : (upper ? CH_A_UP : CH_A_LO) + d - 8'd10;
			ndig++;
			rest = rest / 64'(radix);
		end while (rest != 0 && ndig < DIGIT_CAP);

		// The octal alternate zero is part of the digits, so precision counts it
		// and it survives a zero precision on a zero value.
		if (radix == 8 && alt && f.mag != 0) begin
			digits[ndig] = CH_ZERO;
			ndig++;
		end
		if (f.prec_given && p == 0 && f.mag == 0 && !(radix == 8 && alt))
			ndig = 0;

		if (signed_kind) begin
			if (neg) begin
				prefix[npre] = CH_MINUS;
				npre++;
			end else if (f.plus) begin
				prefix[npre] = CH_PLUS;
				npre++;
			end else if (f.space) begin
				prefix[npre] = CH_SPACE;
				npre++;
			end
		end
		if (radix == 16 && alt && f.mag != 0) begin
			prefix[npre] = CH_ZERO;
			prefix[npre + 1] = upper ? CH_X_UP : CH_X_LO;
			npre += 2;
		end

		// Precision pads first; zero fill only applies without a precision and
		// without left justification.
		zpad = (f.prec_given && ndig < p) ? p - ndig : 0;
		total = npre + zpad + ndig;
		if (f.zfill && !f.prec_given && !f.left && total < w)
			zpad += w - total;
		total = npre + zpad + ndig;
		spaces = (w > total) ? w - total : 0;

		if (!f.left)
			for (i = 0; i < spaces && n < MAX_CHARS; i++) line[n++] = CH_SPACE;
		for (i = 0; i < npre && n < MAX_CHARS; i++) line[n++] = prefix[i];
		for (i = 0; i < zpad && n < MAX_CHARS; i++) line[n++] = CH_ZERO;
		for (i = 0; i < ndig && n < MAX_CHARS; i++) line[n++] = digits[ndig - 1 - i];
		if (f.left)
			for (i = 0; i < spaces && n < MAX_CHARS; i++) line[n++] = CH_SPACE;

		if (n == 0)
			empty_fields++;
		for (i = 0; i < n; i++)
			expected_chars.push_back({i == n - 1, line[i]});
	endtask

	// Sender. An item is accepted when item_valid is high and item_stall low;
	// the bus is then free at the same edge and may take the next item at once.
	// An item marked hold is not put on the bus until every character queued so
	// far has come out.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				format_field(on_bus);
				fields_sent++;
			end
			if (!item_valid || !item_stall) begin
				if (fields_to_send.size() != 0
						&& (steady || $urandom_range(0, 99) >= IDLE_PERCENT)
						&& !(fields_to_send[0].hold && expected_chars.size() != 0)) begin
					on_bus = fields_to_send.pop_front();
					magnitude      <= on_bus.mag;
					negative       <= on_bus.neg;
					mode           <= on_bus.mode;
					left_justify   <= on_bus.left;
					force_plus     <= on_bus.plus;
					space_sign     <= on_bus.space;
					alternate_form <= on_bus.alt;
					zero_fill      <= on_bus.zfill;
					field_width    <= on_bus.width;
					has_precision  <= on_bus.prec_given;
					precision      <= on_bus.prec;
					item_valid     <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	task automatic report_mismatch(input string what, input logic [7:0] want,
			input logic [7:0] got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s mismatch: expected 0x%02h, actual 0x%02h", $time, what, want, got);
	endtask

	// Receiver. Each accepted character is checked against the oldest one still
	// expected; the stall is redrawn every cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_stall <= 1'b0;
		end else begin
			if (char_valid && !char_stall) begin
				chars_checked++;
				if (expected_chars.size() == 0) begin
					report_mismatch("unexpected character", 8'h00, ascii_char);
				end else begin
					next_char = expected_chars.pop_front();
					if (ascii_char !== next_char[7:0])
						report_mismatch("character", next_char[7:0], ascii_char);
					if (last !== next_char[8])
						report_mismatch("last mark", 8'(next_char[8]), 8'(last));
				end
			end
			char_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
		end
	end

	// Watchdog: cycles with no transfer on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (char_valid && !char_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		field_item_t f;
		int k;

		// Directed items: zero with and without digits, the octal zero that
		// survives precision zero, the pointer without prefix for zero, negative
		// zero, the negative mark outside signed mode, sign priority, zero fill
		// overridden by precision and by left justification, both hex cases,
		// full-width values, saturated width and precision, and the unused modes.
		fields_to_send.push_back(make_field(64'd0, MODE_SDEC, FL_NONE, 0, 0, 0, 0));
		fields_to_send.push_back(make_field(64'd0, MODE_SDEC, FL_NONE, 0, 1, 0, 0));
		fields_to_send.push_back(make_field(64'd0, MODE_OCT, FL_ALT, 0, 1, 0, 0));
		fields_to_send.push_back(make_field(64'd0, MODE_PTR, FL_NONE, 0, 0, 0, 0));
		fields_to_send.push_back(make_field(64'h1234abcd, MODE_PTR, FL_PLUS, 0, 0, 0, 0));
		fields_to_send.push_back(make_field(64'd12345, MODE_SDEC, FL_ZERO, 10, 0, 0, 1));
		fields_to_send.push_back(make_field(64'd0, MODE_SDEC, FL_NONE, 0, 0, 0, 1));
		fields_to_send.push_back(make_field(64'd7, MODE_UDEC, FL_PLUS | FL_SPACE, 0, 0, 0, 1));
		fields_to_send.push_back(make_field(64'd42, MODE_SDEC, FL_PLUS | FL_SPACE, 0, 0, 0, 0));
		fields_to_send.push_back(make_field(64'd42, MODE_SDEC, FL_SPACE | FL_LEFT | FL_ZERO,
			6, 0, 0, 0));
		fields_to_send.push_back(make_field(64'hdeadbeef, MODE_HEX, FL_ALT | FL_ZERO,
			16, 0, 0, 1));
		fields_to_send.push_back(make_field({64{1'b1}}, MODE_HEX_UP, FL_ALT, 0, 0, 0, 0));
		fields_to_send.push_back(make_field({64{1'b1}}, MODE_OCT, FL_ALT, 0, 0, 0, 0));
		// The saturated-width field waits until the block has gone quiet.
		f = make_field({64{1'b1}}, MODE_UDEC, FL_NONE, 127, 0, 0, 0);
		f.hold = 1'b1;
		fields_to_send.push_back(f);
		fields_to_send.push_back(make_field(64'h7fffffffffffffff, MODE_SDEC, FL_PLUS,
			0, 1, 63, 0));
		fields_to_send.push_back(make_field({64{1'b1}}, MODE_PTR, FL_PLUS, 0, 1, 63, 1));
		fields_to_send.push_back(make_field(64'd99, MODE_UNUSED6, FL_PLUS, 0, 0, 0, 1));
		fields_to_send.push_back(make_field(64'd0, MODE_UNUSED7, FL_ALT | FL_ZERO,
			5, 0, 0, 0));
		fields_to_send.push_back(make_field(64'd255, MODE_HEX, FL_ZERO, 8, 1, 4, 0));
		fields_to_send.push_back(make_field(64'd5, MODE_SDEC, FL_ZERO | FL_LEFT, 6, 0, 0, 1));
		fields_to_send.push_back(make_field(64'd8, MODE_OCT, FL_ALT, 0, 1, 3, 0));
		fields_to_send.push_back(make_field(64'd0, MODE_HEX, FL_ALT | FL_ZERO, 4, 0, 0, 0));
		fields_to_send.push_back(make_field(64'd0, MODE_HEX_UP, FL_NONE, 3, 1, 0, 0));
		fields_to_send.push_back(make_field(64'd1, MODE_SDEC, FL_LEFT | FL_PLUS, 64, 0, 0, 0));
		fields_to_send.push_back(make_field(64'h8000000000000000, MODE_SDEC, FL_SPACE,
			0, 0, 0, 1));

		for (k = 0; k < RANDOM_FIELDS; k++) begin
			f = random_field();
			f.hold = (k == RANDOM_FIELDS / 2);
			fields_to_send.push_back(f);
		end

		// Everything sent and every character back, then a quiet spell in which
		// any stray character would still be caught.
		while (fields_to_send.size() != 0 || item_valid || expected_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Formatted %0d fields (%0d of them empty) and checked %0d characters,",
			fields_sent, empty_fields, chars_checked);
		$display("covering all modes, every flag, widths to 127 and precisions to 63.");
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

/* sim.f */
hdl/iffmt_pkg.sv
hdl/iffmt_div_step.sv
hdl/iffmt_char_sel.sv
hdl/integer_field_formatter.sv
tb/sv/tb.sv
